### rtl/quintic_bisection_root_finder_top_defines.svh
// Assertion macros shared by the quintic bisection root finder RTL.
`ifndef QUINTIC_BISECTION_ROOT_FINDER_TOP_DEFINES_SVH
`define QUINTIC_BISECTION_ROOT_FINDER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define QBRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define QBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qbrf_pkg.sv
// Shared types and constants of the quintic bisection root finder.
package qbrf_pkg;

  // Result status codes.
  localparam logic [1:0] STAT_NARROWED  = 2'd0;
  localparam logic [1:0] STAT_ROOT      = 2'd1;
  localparam logic [1:0] STAT_NO_CHANGE = 2'd2;

  // Widening limit register value after reset.
  localparam logic [3:0] CFG_RESET = 4'd8;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL_A,
    ST_WAIT_A,
    ST_EVAL_B,
    ST_WAIT_B,
    ST_CHECK,
    ST_HALVE,
    ST_WAIT_C,
    ST_STEP,
    ST_DONE
  } state_t;

  // Polynomial unit phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SQ,
    PH_CUBE,
    PH_FIFTH
  } poly_ph_t;

  // Point at which f is evaluated: lower end, upper end or midpoint.
  typedef enum logic [1:0] {
    PT_A,
    PT_B,
    PT_C
  } pt_t;

  // Source of the reported root.
  typedef enum logic [1:0] {
    RT_NONE,
    RT_A,
    RT_B,
    RT_C
  } root_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       widen;
    logic       eval_go;
    pt_t        pt;
    logic       cap_fa;
    logic       cap_fb;
    logic       step;
    logic       set_res;
    logic [1:0] res_code;
    root_t      root_sel;
    logic       publish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic eval_done;
    logic fa_zero;
    logic fb_zero;
    logic fc_zero;
    logic sign_ab;
    logic widen_more;
    logic halve_more;
    logic out_free;
  } stat_t;

endpackage

### rtl/quintic_bisection_root_finder_top.sv
// Top level of the quintic bisection root finder: stream ports, controller and datapath.
//
// Each input transaction carries an iteration count n and yields exactly one
// result transaction. The block searches for a root of f(x) = x^5 - 10x^3 + x + 3
// in signed fixed point with FRAC_BITS fraction bits. It tests [-1, 1] for a sign
// change of f, widens the interval by one on each side up to min(cfg_data,
// MAX_WIDEN_LIMIT) times while there is none, then halves the bracket n times.
// An exact zero of f at an end or a midpoint stops the search and reports that x.
// Timing is set by the single shared multiplier, which takes one 16-bit digit
// per cycle: with D = ceil((FRAC_BITS + 16) / 16) digits (3 at the default), one
// evaluation of f is three dependent multiplies. A bracket test evaluates both
// ends and each halving evaluates only the midpoint; an exact zero of f can end
// a request early.
// One request is worked at a time; the input is ready again as soon as the result
// is in the output register, while that result may still wait for out_tready.
// The widening limit register resets to 8 and should be written only while idle.
module quintic_bisection_root_finder_top #(
  parameter int FRAC_BITS       = 24,
  parameter int MAX_WIDEN_LIMIT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: widening limit.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data,     // [3:0] max_widen_steps
  // Request stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [5:0] iteration_count, [7:6] zero
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata     // [1:0] status, [33:2] low_bound,
                                     // [65:34] high_bound, [97:66] root_value,
                                     // [103:98] zero
);
  import qbrf_pkg::*;

  `include "quintic_bisection_root_finder_top_defines.svh"

  // Magnitude of x^5 stays below 59049 * 2^FRAC_BITS for |x| <= 9.
  localparam int MAG_W = FRAC_BITS + 16;
  localparam int FW    = MAG_W + 4;

  cmd_t               ctrl_cmd;
  stat_t              dp_stat;
  logic [1:0]         res_status;
  logic signed [31:0] res_low;
  logic signed [31:0] res_high;
  logic signed [31:0] res_root;

  // Accept configuration at any time; the user must issue writes only while idle, the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  qbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  qbrf_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_WIDEN_LIMIT (MAX_WIDEN_LIMIT),
    .MAG_W           (MAG_W),
    .FW              (FW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctrl_cmd),
    .stat       (dp_stat),
    .in_count   (in_tdata[5:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_low    (res_low),
    .out_high   (res_high),
    .out_root   (res_root)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {6'b000000, res_root, res_high, res_low, res_status};

  `QBRF_ASSERT_SAME(a_accept_loads, in_tvalid && in_tready, ctrl_cmd.load, "request accepted without load")
  `QBRF_ASSERT_SAME(a_publish_free, ctrl_cmd.publish, dp_stat.out_free, "result published over a pending one")
  `QBRF_ASSERT_NEXT(a_publish_shows, ctrl_cmd.publish, out_tvalid, "published result not presented")
  `QBRF_ASSERT_SAME(a_root_zero, out_tvalid && (out_tdata[1:0] != STAT_ROOT), out_tdata[97:66] == 32'd0, "root field nonzero without exact root")

endmodule

### rtl/qbrf_mul.sv
// Iterative unsigned fixed-point multiplier, one 16-bit digit of the multiplier per cycle.
module qbrf_mul #(
  parameter int FRAC_BITS = 24,
  parameter int MAG_W     = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] in_x,
  input  logic [MAG_W-1:0] in_y,
  output logic             done,
  output logic [MAG_W-1:0] prod
);
  import qbrf_pkg::*;

  localparam int DIG_W = 16;
  localparam int NCH   = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int YW    = NCH * DIG_W;
  localparam int PW    = MAG_W + YW;
  localparam int IW    = (NCH > 1) ? $clog2(NCH) : 1;

  logic                   busy_r;
  logic                   done_r;
  logic [IW-1:0]          cnt_r;
  logic [MAG_W-1:0]       x_r;
  logic [YW-1:0]          y_r;
  logic [PW-1:0]          acc_r;
  logic [MAG_W+DIG_W-1:0] part;
  logic [PW-1:0]          acc_shr;
  logic                   last;

  // Most significant digit first: shift the sum up and add the next partial product.
  assign part    = x_r * y_r[YW-1 -: DIG_W];
  assign last    = (cnt_r == IW'(NCH - 1));
  assign acc_shr = acc_r >> FRAC_BITS;
  assign prod    = acc_shr[MAG_W-1:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= in_x;
      y_r   <= YW'(in_y);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << DIG_W) + PW'(part);
      y_r   <= y_r << DIG_W;
    end
  end

endmodule

### rtl/qbrf_poly.sv
// Evaluates f(x) = x^5 - 10x^3 + x + 3 on the shared multiplier.
module qbrf_poly #(
  parameter int FRAC_BITS = 24,
  parameter int MAG_W     = 40,
  parameter int FW        = 44
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          x,
  output logic                 done,
  output logic signed [FW-1:0] f
);
  import qbrf_pkg::*;

  localparam logic signed [FW-1:0] THREE_Q = FW'(3) << FRAC_BITS;

  poly_ph_t               ph_r;
  poly_ph_t               ph_nxt;
  logic                   done_r;
  logic                   neg_r;
  logic [MAG_W-1:0]       ax_r;
  logic [MAG_W-1:0]       x2_r;
  logic [MAG_W-1:0]       x3_r;
  logic signed [FW-1:0]   f_r;
  logic [31:0]            abs32;
  logic [MAG_W-1:0]       ax_in;
  logic                   mul_go;
  logic [MAG_W-1:0]       mul_x;
  logic [MAG_W-1:0]       mul_y;
  logic                   mul_done;
  logic [MAG_W-1:0]       mul_res;
  logic signed [FW-1:0]   t_mag;
  logic signed [FW-1:0]   f_calc;

  assign abs32 = x[31] ? (32'd0 - x) : x;
  assign ax_in = MAG_W'(abs32);

  // Work on magnitudes; odd powers take the sign of x.
  assign t_mag  = FW'(mul_res) - FW'({x3_r, 3'b000}) - FW'({x3_r, 1'b0}) + FW'(ax_r);
  assign f_calc = (neg_r ? -t_mag : t_mag) + THREE_Q;

  assign done = done_r;
  assign f    = f_r;

  qbrf_mul #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (MAG_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .in_x  (mul_x),
    .in_y  (mul_y),
    .done  (mul_done),
    .prod  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == PH_FIFTH) && mul_done;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    mul_go = 1'b0;
    mul_x  = ax_in;
    mul_y  = ax_in;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          mul_go = 1'b1;
          ph_nxt = PH_SQ;
        end
      end
      PH_SQ: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_x  = mul_res;
          mul_y  = ax_r;
          ph_nxt = PH_CUBE;
        end
      end
      PH_CUBE: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_x  = mul_res;
          mul_y  = x2_r;
          ph_nxt = PH_FIFTH;
        end
      end
      PH_FIFTH: begin
        if (mul_done) begin
          ph_nxt = PH_IDLE;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && (ph_r == PH_IDLE)) begin
      neg_r <= x[31];
      ax_r  <= ax_in;
    end
    if (mul_done && (ph_r == PH_SQ)) begin
      x2_r <= mul_res;
    end
    if (mul_done && (ph_r == PH_CUBE)) begin
      x3_r <= mul_res;
    end
    if (mul_done && (ph_r == PH_FIFTH)) begin
      f_r <= f_calc;
    end
  end

endmodule

### rtl/qbrf_dp.sv
// Datapath: interval ends, cached f values, counters, config and result registers.
module qbrf_dp #(
  parameter int FRAC_BITS       = 24,
  parameter int MAX_WIDEN_LIMIT = 8,
  parameter int MAG_W           = 40,
  parameter int FW              = 44
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qbrf_pkg::cmd_t      cmd,
  output qbrf_pkg::stat_t     stat,
  input  logic [5:0]          in_count,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_low,
  output logic signed [31:0]  out_high,
  output logic signed [31:0]  out_root
);
  import qbrf_pkg::*;

  localparam logic [31:0] ONE_Q     = 32'd1 << FRAC_BITS;
  localparam logic [3:0]  WIDEN_CAP = 4'(MAX_WIDEN_LIMIT);

  logic [3:0]           cfg_r;
  logic [31:0]          a_r;
  logic [31:0]          b_r;
  logic [31:0]          c_r;
  logic signed [FW-1:0] fa_r;
  logic signed [FW-1:0] fb_r;
  logic [5:0]           n_r;
  logic [5:0]           halved_r;
  logic [3:0]           widened_r;
  logic [1:0]           res_code_r;
  logic [31:0]          res_root_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_low_r;
  logic [31:0]          out_high_r;
  logic [31:0]          out_root_r;
  logic [32:0]          diff;
  logic [31:0]          c_mid;
  logic [31:0]          poly_x;
  logic [31:0]          root_pick;
  logic [3:0]           widen_lim;
  logic                 f_done;
  logic signed [FW-1:0] f_val;
  logic                 sign_ac;

  // Midpoint: lo + floor((hi - lo) / 2); hi is always above lo.
  assign diff  = {b_r[31], b_r} - {a_r[31], a_r};
  assign c_mid = a_r + diff[32:1];

  assign widen_lim = (cfg_r > WIDEN_CAP) ? WIDEN_CAP : cfg_r;
  assign sign_ac   = (fa_r != '0) && (f_val != '0) && (fa_r[FW-1] != f_val[FW-1]);

  always_comb begin
    case (cmd.pt)
      PT_A:    poly_x = a_r;
      PT_B:    poly_x = b_r;
      default: poly_x = c_mid;
    endcase
  end

  always_comb begin
    case (cmd.root_sel)
      RT_A:    root_pick = a_r;
      RT_B:    root_pick = b_r;
      RT_C:    root_pick = c_r;
      default: root_pick = '0;
    endcase
  end

  qbrf_poly #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (MAG_W),
    .FW        (FW)
  ) u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.eval_go),
    .x     (poly_x),
    .done  (f_done),
    .f     (f_val)
  );

  always_comb begin
    stat.eval_done  = f_done;
    stat.fa_zero    = (fa_r == '0);
    stat.fb_zero    = (fb_r == '0);
    stat.fc_zero    = (f_val == '0);
    stat.sign_ab    = (fa_r != '0) && (fb_r != '0) && (fa_r[FW-1] != fb_r[FW-1]);
    stat.widen_more = (widened_r < widen_lim);
    stat.halve_more = (halved_r < n_r);
    stat.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
      halved_r    <= '0;
      widened_r   <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        halved_r  <= '0;
        widened_r <= '0;
      end
      if (cmd.widen) begin
        widened_r <= widened_r + 1'b1;
      end
      if (cmd.step) begin
        halved_r <= halved_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= 32'd0 - ONE_Q;
      b_r <= ONE_Q;
      n_r <= in_count;
    end
    if (cmd.widen) begin
      a_r <= a_r - ONE_Q;
      b_r <= b_r + ONE_Q;
    end
    if (cmd.eval_go && (cmd.pt == PT_C)) begin
      c_r <= c_mid;
    end
    if (cmd.cap_fa) begin
      fa_r <= f_val;
    end
    if (cmd.cap_fb) begin
      fb_r <= f_val;
    end
    // Keep the half where f changes sign; f at the lower end follows the lower end.
    if (cmd.step) begin
      if (sign_ac) begin
        b_r <= c_r;
      end else begin
        a_r  <= c_r;
        fa_r <= f_val;
      end
    end
    if (cmd.set_res) begin
      res_code_r <= cmd.res_code;
      res_root_r <= root_pick;
    end
    if (cmd.publish) begin
      out_status_r <= res_code_r;
      out_low_r    <= a_r;
      out_high_r   <= b_r;
      out_root_r   <= res_root_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_low    = out_low_r;
  assign out_high   = out_high_r;
  assign out_root   = out_root_r;

endmodule

### rtl/qbrf_ctrl.sv
// Controller state machine: bracket search, widening, halving and result hand-off.
module qbrf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  qbrf_pkg::stat_t stat,
  output qbrf_pkg::cmd_t  cmd
);
  import qbrf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.pt       = PT_A;
    cmd.root_sel = RT_NONE;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL_A;
        end
      end
      ST_EVAL_A: begin
        cmd.eval_go = 1'b1;
        cmd.pt      = PT_A;
        state_nxt   = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (stat.eval_done) begin
          cmd.cap_fa = 1'b1;
          state_nxt  = ST_EVAL_B;
        end
      end
      ST_EVAL_B: begin
        cmd.eval_go = 1'b1;
        cmd.pt      = PT_B;
        state_nxt   = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (stat.eval_done) begin
          cmd.cap_fb = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.fa_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = STAT_ROOT;
          cmd.root_sel = RT_A;
          state_nxt    = ST_DONE;
        end else if (stat.fb_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = STAT_ROOT;
          cmd.root_sel = RT_B;
          state_nxt    = ST_DONE;
        end else if (stat.sign_ab) begin
          state_nxt = ST_HALVE;
        end else if (stat.widen_more) begin
          cmd.widen = 1'b1;
          state_nxt = ST_EVAL_A;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = STAT_NO_CHANGE;
          state_nxt    = ST_DONE;
        end
      end
      ST_HALVE: begin
        if (stat.halve_more) begin
          cmd.eval_go = 1'b1;
          cmd.pt      = PT_C;
          state_nxt   = ST_WAIT_C;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = STAT_NARROWED;
          state_nxt    = ST_DONE;
        end
      end
      ST_WAIT_C: begin
        if (stat.eval_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (stat.fc_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = STAT_ROOT;
          cmd.root_sel = RT_C;
          state_nxt    = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_HALVE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
